[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is high
`define CPID_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked check, active through reset
`define CPID_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/cpid_pkg.sv]
// ----------------------------------------------------------------------------
// cpid_pkg
// Types, register indexes and format constants of the clamped PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package cpid_pkg;

   localparam int SIGNAL_WIDTH_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF = 8;
   localparam int INTEG_FRAC         = 16;
   localparam int GAIN_W             = 16;
   localparam int LIMIT_W            = 15;
   localparam int BOUND_W            = 16;
   localparam int INTEG_W            = LIMIT_W + INTEG_FRAC + 1;
   localparam int CSR_INDEX_W        = 4;
   localparam int CSR_DATA_W         = 16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KP,
      CSR_KI_STEP,
      CSR_KD,
      CSR_P_LIMIT,
      CSR_I_LIMIT,
      CSR_D_LIMIT,
      CSR_OUT_MAX,
      CSR_OUT_MIN
   } csr_index_type;

   typedef struct packed {
      logic [GAIN_W-1:0]         kp;
      logic [GAIN_W-1:0]         ki_step;
      logic [GAIN_W-1:0]         kd;
      logic [LIMIT_W-1:0]        p_limit;
      logic [LIMIT_W-1:0]        i_limit;
      logic [LIMIT_W-1:0]        d_limit;
      logic signed [BOUND_W-1:0] out_max;
      logic signed [BOUND_W-1:0] out_min;
   } cpid_cfg_type;

   localparam cpid_cfg_type CFG_RESET = '{
      kp:      16'd1792,
      ki_step: 16'd0,
      kd:      16'd0,
      p_limit: 15'd300,
      i_limit: 15'd0,
      d_limit: 15'd0,
      out_max: 16'sd300,
      out_min: -16'sd300
   };

endpackage

`default_nettype wire

[src/cpid_product_stage.sv]
// ----------------------------------------------------------------------------
// cpid_product_stage
// Forms the error and the three gain products of a sample and registers them.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_product_stage #(
   parameter int SIGNAL_WIDTH = cpid_pkg::SIGNAL_WIDTH_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cpid_pkg::cpid_cfg_type                  cfg,
   input  wire logic                                    in_valid,
   output logic                                         in_ready,
   input  wire logic signed [SIGNAL_WIDTH-1:0]          in_target,
   input  wire logic signed [SIGNAL_WIDTH-1:0]          in_measured,
   input  wire logic signed [SIGNAL_WIDTH-1:0]          in_change,
   output logic                                         out_valid,
   input  wire logic                                    out_ready,
   output logic signed [SIGNAL_WIDTH:0]                 out_err,
   output logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] out_p_raw,
   output logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] out_incr,
   output logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] out_d_raw
);
   import cpid_pkg::*;

   localparam int ERR_W  = SIGNAL_WIDTH + 1;
   localparam int PROD_W = SIGNAL_WIDTH + GAIN_W + 2;

   logic                     valid_ff;
   logic                     valid_in;
   logic                     load;
   logic signed [ERR_W-1:0]  err_c;
   logic signed [ERR_W-1:0]  neg_change_c;
   logic signed [PROD_W-1:0] p_c;
   logic signed [PROD_W-1:0] incr_c;
   logic signed [PROD_W-1:0] d_c;
   logic signed [ERR_W-1:0]  err_ff;
   logic signed [PROD_W-1:0] p_ff;
   logic signed [PROD_W-1:0] incr_ff;
   logic signed [PROD_W-1:0] d_ff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign err_c        = ERR_W'(in_target) - ERR_W'(in_measured);
   assign neg_change_c = -ERR_W'(in_change);
   assign p_c          = $signed({1'b0, cfg.kp}) * err_c;
   assign incr_c       = $signed({1'b0, cfg.ki_step}) * err_c;
   assign d_c          = $signed({1'b0, cfg.kd}) * neg_change_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff  <= err_c;
         p_ff    <= p_c;
         incr_ff <= incr_c;
         d_ff    <= d_c;
      end
   end

   assign out_valid = valid_ff;
   assign out_err   = err_ff;
   assign out_p_raw = p_ff;
   assign out_incr  = incr_ff;
   assign out_d_raw = d_ff;

endmodule

`default_nettype wire

[src/cpid_clamp_stage.sv]
// ----------------------------------------------------------------------------
// cpid_clamp_stage
// Updates and clamps the integrator, clamps the P and D terms.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cpid_clamp_stage #(
   parameter int SIGNAL_WIDTH   = cpid_pkg::SIGNAL_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                       clock,
   input  wire logic                                       reset,
   input  wire cpid_pkg::cpid_cfg_type                     cfg,
   input  wire logic                                       in_valid,
   output logic                                            in_ready,
   input  wire logic signed [SIGNAL_WIDTH:0]               in_err,
   input  wire logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] in_p_raw,
   input  wire logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] in_incr,
   input  wire logic signed [SIGNAL_WIDTH+cpid_pkg::GAIN_W+1:0] in_d_raw,
   output logic                                            out_valid,
   input  wire logic                                       out_ready,
   output logic signed [SIGNAL_WIDTH:0]                    out_err,
   output logic signed [GAIN_FRAC_BITS+cpid_pkg::LIMIT_W:0] out_p,
   output logic signed [GAIN_FRAC_BITS+cpid_pkg::LIMIT_W:0] out_d,
   output logic signed [cpid_pkg::INTEG_W-1:0]             out_integ
);
   import cpid_pkg::*;

   localparam int ERR_W  = SIGNAL_WIDTH + 1;
   localparam int PROD_W = SIGNAL_WIDTH + GAIN_W + 2;
   localparam int TERM_W = GAIN_FRAC_BITS + LIMIT_W + 1;
   localparam int CMP_W  = (PROD_W > TERM_W) ? PROD_W : TERM_W;
   localparam int ACC_W  = ((PROD_W > INTEG_W) ? PROD_W : INTEG_W) + 1;

   function automatic logic signed [TERM_W-1:0] clamp_term(
      input logic signed [PROD_W-1:0] v,
      input logic [LIMIT_W-1:0]       lim
   );
      logic signed [CMP_W-1:0]  ve;
      logic signed [CMP_W-1:0]  le;
      logic signed [TERM_W-1:0] r;
      ve = CMP_W'(v);
      le = $signed(CMP_W'(lim) << GAIN_FRAC_BITS);
      priority if (ve > le) begin
         r = TERM_W'(le);
      end else if (ve < -le) begin
         r = TERM_W'(-le);
      end else begin
         r = TERM_W'(ve);
      end
      return r;
   endfunction

   logic                      valid_ff;
   logic                      valid_in;
   logic                      load;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [TERM_W-1:0]  p_ff;
   logic signed [TERM_W-1:0]  d_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [INTEG_W-1:0] integ_in;
   logic signed [ACC_W-1:0]   acc_c;
   logic signed [ACC_W-1:0]   acc_bound;
   logic signed [INTEG_W-1:0] i_bound;
   logic signed [TERM_W-1:0]  p_bound;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign i_bound   = $signed(INTEG_W'(cfg.i_limit) << INTEG_FRAC);
   assign p_bound   = $signed(TERM_W'(cfg.p_limit) << GAIN_FRAC_BITS);
   assign acc_bound = ACC_W'(i_bound);
   assign acc_c     = ACC_W'(integ_ff) + ACC_W'(in_incr);

   always_comb begin
      integ_in = integ_ff;
      if (load) begin
         priority if (acc_c > acc_bound) begin
            integ_in = i_bound;
         end else if (acc_c < -acc_bound) begin
            integ_in = -i_bound;
         end else begin
            integ_in = INTEG_W'(acc_c);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         integ_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         err_ff <= in_err;
         p_ff   <= clamp_term(in_p_raw, cfg.p_limit);
         d_ff   <= clamp_term(in_d_raw, cfg.d_limit);
      end
   end

   assign out_valid = valid_ff;
   assign out_err   = err_ff;
   assign out_p     = p_ff;
   assign out_d     = d_ff;
   assign out_integ = integ_ff;

   `CPID_ASSERT(a_integ_in_bound, clock, reset,
      valid_ff |-> (integ_ff <= i_bound && integ_ff >= -i_bound),
      "integrator outside its limit")
   `CPID_ASSERT(a_integ_hold, clock, reset,
      !load |=> $stable(integ_ff),
      "integrator moved without a transfer")
   `CPID_ASSERT(a_p_in_bound, clock, reset,
      valid_ff |-> (p_ff <= p_bound && p_ff >= -p_bound),
      "proportional term outside its limit")

endmodule

`default_nettype wire

[src/cpid_output_stage.sv]
// ----------------------------------------------------------------------------
// cpid_output_stage
// Sums the terms, saturates the drive and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module cpid_output_stage #(
   parameter int SIGNAL_WIDTH   = cpid_pkg::SIGNAL_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                        clock,
   input  wire logic                                        reset,
   input  wire cpid_pkg::cpid_cfg_type                      cfg,
   input  wire logic                                        in_valid,
   output logic                                             in_ready,
   input  wire logic signed [SIGNAL_WIDTH:0]                in_err,
   input  wire logic signed [GAIN_FRAC_BITS+cpid_pkg::LIMIT_W:0] in_p,
   input  wire logic signed [GAIN_FRAC_BITS+cpid_pkg::LIMIT_W:0] in_d,
   input  wire logic signed [cpid_pkg::INTEG_W-1:0]         in_integ,
   output logic                                             out_valid,
   input  wire logic                                        out_ready,
   output logic signed [SIGNAL_WIDTH-1:0]                   out_drive,
   output logic signed [SIGNAL_WIDTH-1:0]                   out_prop_term,
   output logic signed [SIGNAL_WIDTH-1:0]                   out_integ_term,
   output logic signed [SIGNAL_WIDTH-1:0]                   out_deriv_term,
   output logic signed [SIGNAL_WIDTH:0]                     out_error_value
);
   import cpid_pkg::*;

   localparam int ERR_W    = SIGNAL_WIDTH + 1;
   localparam int TERM_W   = GAIN_FRAC_BITS + LIMIT_W + 1;
   localparam int SUM_W    = INTEG_W + 2;
   localparam int UP_SHIFT = INTEG_FRAC - GAIN_FRAC_BITS;

   logic                           valid_ff;
   logic                           valid_in;
   logic                           load;
   logic signed [SUM_W-1:0]        sum_c;
   logic signed [SUM_W-1:0]        sum_bias;
   logic signed [SUM_W-1:0]        sum_tr;
   logic signed [SUM_W-1:0]        hi_c;
   logic signed [SUM_W-1:0]        lo_c;
   logic signed [TERM_W-1:0]       p_bias;
   logic signed [TERM_W-1:0]       d_bias;
   logic signed [TERM_W-1:0]       p_tr;
   logic signed [TERM_W-1:0]       d_tr;
   logic signed [INTEG_W-1:0]      i_bias;
   logic signed [INTEG_W-1:0]      i_tr;
   logic signed [SIGNAL_WIDTH-1:0] drive_c;
   logic signed [SIGNAL_WIDTH-1:0] drive_ff;
   logic signed [SIGNAL_WIDTH-1:0] prop_ff;
   logic signed [SIGNAL_WIDTH-1:0] integ_ff;
   logic signed [SIGNAL_WIDTH-1:0] deriv_ff;
   logic signed [ERR_W-1:0]        err_ff;

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   assign sum_c = (SUM_W'(in_p) <<< UP_SHIFT) + SUM_W'(in_integ)
                + (SUM_W'(in_d) <<< UP_SHIFT);
   assign hi_c  = SUM_W'(cfg.out_max) <<< INTEG_FRAC;
   assign lo_c  = SUM_W'(cfg.out_min) <<< INTEG_FRAC;

   // round toward zero: bias negative values before the arithmetic shift
   assign sum_bias = {{(SUM_W-INTEG_FRAC){1'b0}}, {INTEG_FRAC{sum_c[SUM_W-1]}}};
   assign sum_tr   = (sum_c + sum_bias) >>> INTEG_FRAC;
   assign p_bias   = {{(TERM_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{in_p[TERM_W-1]}}};
   assign p_tr     = (in_p + p_bias) >>> GAIN_FRAC_BITS;
   assign d_bias   = {{(TERM_W-GAIN_FRAC_BITS){1'b0}}, {GAIN_FRAC_BITS{in_d[TERM_W-1]}}};
   assign d_tr     = (in_d + d_bias) >>> GAIN_FRAC_BITS;
   assign i_bias   = {{(INTEG_W-INTEG_FRAC){1'b0}}, {INTEG_FRAC{in_integ[INTEG_W-1]}}};
   assign i_tr     = (in_integ + i_bias) >>> INTEG_FRAC;

   always_comb begin
      priority if (sum_c < hi_c && sum_c > lo_c) begin
         drive_c = SIGNAL_WIDTH'(sum_tr);
      end else if (sum_c >= hi_c) begin
         drive_c = SIGNAL_WIDTH'(cfg.out_max);
      end else begin
         drive_c = SIGNAL_WIDTH'(cfg.out_min);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         drive_ff <= drive_c;
         prop_ff  <= SIGNAL_WIDTH'(p_tr);
         integ_ff <= SIGNAL_WIDTH'(i_tr);
         deriv_ff <= SIGNAL_WIDTH'(d_tr);
         err_ff   <= in_err;
      end
   end

   assign out_valid       = valid_ff;
   assign out_drive       = drive_ff;
   assign out_prop_term   = prop_ff;
   assign out_integ_term  = integ_ff;
   assign out_deriv_term  = deriv_ff;
   assign out_error_value = err_ff;

endmodule

`default_nettype wire

[src/clamped_pid_controller_unit.sv]
// ----------------------------------------------------------------------------
// clamped_pid_controller_unit
// Fixed-point PID step with per-term clamping, integrator anti-windup and
// drive saturation.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_ready   target, measured, measured_change
//   rsp      out        rsp_valid/rsp_ready   drive, three terms, error_value
//   csr      in         csr_valid/csr_ready   csr_index, csr_data
//
// One sample per cycle sustained while rsp_ready holds high; each result
// passes through the product, clamp and output register stages in turn.
// The integrator is updated as a sample enters the clamp stage.
// A stalled rsp side backs up the stages one by one; req_ready drops only
// when all three hold a sample. csr_ready is always high.
// Synchronous reset loads the register defaults and zeroes the integrator.
// ----------------------------------------------------------------------------
`default_nettype none

module clamped_pid_controller_unit #(
   parameter int SIGNAL_WIDTH   = cpid_pkg::SIGNAL_WIDTH_DEF,
   parameter int GAIN_FRAC_BITS = cpid_pkg::GAIN_FRAC_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic signed [SIGNAL_WIDTH-1:0]       req_target,
   input  wire logic signed [SIGNAL_WIDTH-1:0]       req_measured,
   input  wire logic signed [SIGNAL_WIDTH-1:0]       req_measured_change,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed [SIGNAL_WIDTH-1:0]            rsp_drive,
   output logic signed [SIGNAL_WIDTH-1:0]            rsp_prop_term,
   output logic signed [SIGNAL_WIDTH-1:0]            rsp_integ_term,
   output logic signed [SIGNAL_WIDTH-1:0]            rsp_deriv_term,
   output logic signed [SIGNAL_WIDTH:0]              rsp_error_value,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [cpid_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [cpid_pkg::CSR_DATA_W-1:0]      csr_data
);
   import cpid_pkg::*;

   localparam int ERR_W  = SIGNAL_WIDTH + 1;
   localparam int PROD_W = SIGNAL_WIDTH + GAIN_W + 2;
   localparam int TERM_W = GAIN_FRAC_BITS + LIMIT_W + 1;

   cpid_cfg_type cfg_ff;
   cpid_cfg_type cfg_in;

   logic                      s1_valid;
   logic                      s1_ready;
   logic signed [ERR_W-1:0]   s1_err;
   logic signed [PROD_W-1:0]  s1_p_raw;
   logic signed [PROD_W-1:0]  s1_incr;
   logic signed [PROD_W-1:0]  s1_d_raw;
   logic                      s2_valid;
   logic                      s2_ready;
   logic signed [ERR_W-1:0]   s2_err;
   logic signed [TERM_W-1:0]  s2_p;
   logic signed [TERM_W-1:0]  s2_d;
   logic signed [INTEG_W-1:0] s2_integ;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_KP:      cfg_in.kp      = csr_data;
            CSR_KI_STEP: cfg_in.ki_step = csr_data;
            CSR_KD:      cfg_in.kd      = csr_data;
            CSR_P_LIMIT: cfg_in.p_limit = csr_data[LIMIT_W-1:0];
            CSR_I_LIMIT: cfg_in.i_limit = csr_data[LIMIT_W-1:0];
            CSR_D_LIMIT: cfg_in.d_limit = csr_data[LIMIT_W-1:0];
            CSR_OUT_MAX: cfg_in.out_max = $signed(csr_data);
            CSR_OUT_MIN: cfg_in.out_min = $signed(csr_data);
            default: begin
               // drop writes beyond the register list
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpid_product_stage #(
      .SIGNAL_WIDTH (SIGNAL_WIDTH)
   ) u_product (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .in_target   (req_target),
      .in_measured (req_measured),
      .in_change   (req_measured_change),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .out_err     (s1_err),
      .out_p_raw   (s1_p_raw),
      .out_incr    (s1_incr),
      .out_d_raw   (s1_d_raw)
   );

   cpid_clamp_stage #(
      .SIGNAL_WIDTH   (SIGNAL_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_clamp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_err    (s1_err),
      .in_p_raw  (s1_p_raw),
      .in_incr   (s1_incr),
      .in_d_raw  (s1_d_raw),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_err   (s2_err),
      .out_p     (s2_p),
      .out_d     (s2_d),
      .out_integ (s2_integ)
   );

   cpid_output_stage #(
      .SIGNAL_WIDTH   (SIGNAL_WIDTH),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_output (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .in_valid        (s2_valid),
      .in_ready        (s2_ready),
      .in_err          (s2_err),
      .in_p            (s2_p),
      .in_d            (s2_d),
      .in_integ        (s2_integ),
      .out_valid       (rsp_valid),
      .out_ready       (rsp_ready),
      .out_drive       (rsp_drive),
      .out_prop_term   (rsp_prop_term),
      .out_integ_term  (rsp_integ_term),
      .out_deriv_term  (rsp_deriv_term),
      .out_error_value (rsp_error_value)
   );

endmodule

`default_nettype wire

[test/clamped_pid_controller_unit_tb.sv]
// ----------------------------------------------------------------------------
// clamped_pid_controller_unit_tb
// Drives control samples through the PID unit under several gain, limit and
// bound settings, predicts every result with its own fixed-point PID step and
// checks drive, the three clamped terms and the error field by field, with
// random gaps on both channels, a long output stall and a watchdog.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clamped_pid_controller_unit_tb;

   import cpid_pkg::*;

   localparam int SW             = SIGNAL_WIDTH_DEF;
   localparam int GAIN_FRAC      = GAIN_FRAC_BITS_DEF;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_STEPS    = 118;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE_LO = 4'd8;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_SPARE_HI = 4'd15;

   typedef struct {
      logic signed [SW-1:0] drive;
      logic signed [SW-1:0] prop_term;
      logic signed [SW-1:0] integ_term;
      logic signed [SW-1:0] deriv_term;
      logic signed [SW:0]   error_value;
   } pid_result_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic signed [SW-1:0]         req_target;
   logic signed [SW-1:0]         req_measured;
   logic signed [SW-1:0]         req_measured_change;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [SW-1:0]         rsp_drive;
   logic signed [SW-1:0]         rsp_prop_term;
   logic signed [SW-1:0]         rsp_integ_term;
   logic signed [SW-1:0]         rsp_deriv_term;
   logic signed [SW:0]           rsp_error_value;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [CSR_INDEX_W-1:0]       csr_index;
   logic [CSR_DATA_W-1:0]        csr_data;

   cpid_cfg_type                 pid_settings = CFG_RESET;
   longint                       integ_acc = 0;
   pid_result_type               pending_results[$];
   int                           mismatch_count = 0;
   int                           idle_cycles = 0;
   int unsigned                  send_gap_pct = 0;
   int unsigned                  rsp_stall_pct = 0;
   int                           rsp_hold_cycles = 0;

   clamped_pid_controller_unit DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_target          (req_target),
      .req_measured        (req_measured),
      .req_measured_change (req_measured_change),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive           (rsp_drive),
      .rsp_prop_term       (rsp_prop_term),
      .rsp_integ_term      (rsp_integ_term),
      .rsp_deriv_term      (rsp_deriv_term),
      .rsp_error_value     (rsp_error_value),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ------------------------------------------------------------------
   // fixed-point PID step
   // ------------------------------------------------------------------
   function automatic longint clamp_mag(input longint v, input longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic pid_result_type predict_pid_step(input logic signed [SW-1:0] tgt,
                                                       input logic signed [SW-1:0] meas,
                                                       input logic signed [SW-1:0] chg);
      longint         err;
      longint         p_val;
      longint         d_val;
      longint         sum;
      longint         upper;
      longint         lower;
      longint         drive_val;
      longint         prop_val;
      longint         integ_val;
      longint         deriv_val;
      pid_result_type r;
      err = longint'(tgt) - longint'(meas);
      integ_acc = clamp_mag(integ_acc + err * longint'(pid_settings.ki_step),
                            longint'(pid_settings.i_limit) <<< INTEG_FRAC);
      p_val = clamp_mag(longint'(pid_settings.kp) * err,
                        longint'(pid_settings.p_limit) <<< GAIN_FRAC);
      d_val = clamp_mag(-longint'(pid_settings.kd) * longint'(chg),
                        longint'(pid_settings.d_limit) <<< GAIN_FRAC);
      sum = (p_val <<< (INTEG_FRAC - GAIN_FRAC)) + integ_acc
            + (d_val <<< (INTEG_FRAC - GAIN_FRAC));
      upper = longint'($signed(pid_settings.out_max)) <<< INTEG_FRAC;
      lower = longint'($signed(pid_settings.out_min)) <<< INTEG_FRAC;
      if (sum < upper && sum > lower) drive_val = sum / (longint'(1) <<< INTEG_FRAC);
      else if (sum >= upper) drive_val = longint'($signed(pid_settings.out_max));
      else drive_val = longint'($signed(pid_settings.out_min));
      prop_val  = p_val / (longint'(1) <<< GAIN_FRAC);
      integ_val = integ_acc / (longint'(1) <<< INTEG_FRAC);
      deriv_val = d_val / (longint'(1) <<< GAIN_FRAC);
      r.drive       = drive_val[SW-1:0];
      r.prop_term   = prop_val[SW-1:0];
      r.integ_term  = integ_val[SW-1:0];
      r.deriv_term  = deriv_val[SW-1:0];
      r.error_value = err[SW:0];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------
   task automatic compare_field(input string name, input logic signed [SW:0] want,
                                input logic signed [SW:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_check
      pid_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            $display("%0t unexpected result transfer, drive %0d", $time, rsp_drive);
         end else begin
            want = pending_results.pop_front();
            compare_field("drive", (SW+1)'(want.drive), (SW+1)'(rsp_drive));
            compare_field("prop_term", (SW+1)'(want.prop_term), (SW+1)'(rsp_prop_term));
            compare_field("integ_term", (SW+1)'(want.integ_term), (SW+1)'(rsp_integ_term));
            compare_field("deriv_term", (SW+1)'(want.deriv_term), (SW+1)'(rsp_deriv_term));
            compare_field("error_value", want.error_value, rsp_error_value);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // result receiver: random stalls, plus long holds on request
   // ------------------------------------------------------------------
   function automatic int stall_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   initial begin : rsp_receiver
      int stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (rsp_hold_cycles > 0) begin
            stall_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(99) < rsp_stall_pct) begin
            stall_left = stall_length() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // sample and register transfers
   // ------------------------------------------------------------------
   function automatic int send_gap();
      if ($urandom_range(99) < send_gap_pct) return stall_length();
      return 0;
   endfunction

   task automatic send_step(input logic signed [SW-1:0] tgt, input logic signed [SW-1:0] meas,
                            input logic signed [SW-1:0] chg, input int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid           <= 1'b1;
      req_target          <= tgt;
      req_measured        <= meas;
      req_measured_change <= chg;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(predict_pid_step(tgt, meas, chg));
      @(negedge clock);
   endtask

   task automatic wait_all_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_results.size() != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
      case (idx)
         CSR_KP:      pid_settings.kp      = data;
         CSR_KI_STEP: pid_settings.ki_step = data;
         CSR_KD:      pid_settings.kd      = data;
         CSR_P_LIMIT: pid_settings.p_limit = data[LIMIT_W-1:0];
         CSR_I_LIMIT: pid_settings.i_limit = data[LIMIT_W-1:0];
         CSR_D_LIMIT: pid_settings.d_limit = data[LIMIT_W-1:0];
         CSR_OUT_MAX: pid_settings.out_max = data;
         CSR_OUT_MIN: pid_settings.out_min = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // limit writes carry a random top bit that the register must drop
   task automatic apply_settings(input cpid_cfg_type c);
      write_reg(CSR_KP, c.kp);
      write_reg(CSR_KI_STEP, c.ki_step);
      write_reg(CSR_KD, c.kd);
      write_reg(CSR_P_LIMIT, {1'($urandom), c.p_limit});
      write_reg(CSR_I_LIMIT, {1'($urandom), c.i_limit});
      write_reg(CSR_D_LIMIT, {1'($urandom), c.d_limit});
      write_reg(CSR_OUT_MAX, c.out_max);
      write_reg(CSR_OUT_MIN, c.out_min);
      csr_valid <= 1'b0;
   endtask

   function automatic cpid_cfg_type make_settings(input logic [GAIN_W-1:0] kp,
                                                  input logic [GAIN_W-1:0] ki,
                                                  input logic [GAIN_W-1:0] kd,
                                                  input logic [LIMIT_W-1:0] plim,
                                                  input logic [LIMIT_W-1:0] ilim,
                                                  input logic [LIMIT_W-1:0] dlim,
                                                  input logic signed [BOUND_W-1:0] omax,
                                                  input logic signed [BOUND_W-1:0] omin);
      cpid_cfg_type c;
      c.kp = kp; c.ki_step = ki; c.kd = kd;
      c.p_limit = plim; c.i_limit = ilim; c.d_limit = dlim;
      c.out_max = omax; c.out_min = omin;
      return c;
   endfunction

   function automatic logic [GAIN_W-1:0] pick_gain(input int unsigned typical);
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return GAIN_W'($urandom);
         default: return GAIN_W'($urandom_range(typical));
      endcase
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2, 3:    return LIMIT_W'($urandom);
         default: return LIMIT_W'($urandom_range(2000));
      endcase
   endfunction

   function automatic cpid_cfg_type random_settings();
      cpid_cfg_type         c;
      logic signed [BOUND_W-1:0] a;
      logic signed [BOUND_W-1:0] b;
      c.kp      = pick_gain(2047);
      c.ki_step = pick_gain(4095);
      c.kd      = pick_gain(2047);
      c.p_limit = pick_limit();
      c.i_limit = pick_limit();
      c.d_limit = pick_limit();
      a = BOUND_W'($urandom);
      b = BOUND_W'($urandom);
      case ($urandom_range(4))
         0: begin
            c.out_max = 16'sh7FFF;
            c.out_min = -16'sh8000;
         end
         1: begin
            c.out_max = a;
            c.out_min = b;
         end
         default: begin
            c.out_max = (a > b) ? a : b;
            c.out_min = (a > b) ? b : a;
         end
      endcase
      return c;
   endfunction

   function automatic logic signed [SW-1:0] random_signal();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return -16'sh8000;
         2, 3:    return SW'($urandom_range(400)) - 16'sd200;
         default: return SW'($urandom);
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   task automatic test_reset_defaults();
      send_step(0, 0, 0, 0);
      send_step(10, 0, 0, 0);
      send_step(-5, 3, 16'sh7FFF, 0);
      send_step(16'sh7FFF, -16'sh8000, 0, 0);
      send_step(-16'sh8000, 16'sh7FFF, -16'sh8000, 0);
      wait_all_results();
   endtask

   task automatic test_gain_extremes();
      apply_settings(make_settings('1, '1, '1, '1, '1, '1, 16'sh7FFF, -16'sh8000));
      send_step(16'sh7FFF, -16'sh8000, -16'sh8000, 0);
      send_step(-16'sh8000, 16'sh7FFF, 16'sh7FFF, 0);
      send_step(1, 0, 1, 0);
      send_step(0, 1, -1, 0);
      send_step(3, 0, 0, 0);
      send_step(3, 0, 0, 0);
      wait_all_results();
   endtask

   task automatic test_zero_limits();
      // spare indexes take no effect
      write_reg(CSR_INDEX_SPARE_LO, 16'hFFFF);
      write_reg(CSR_INDEX_SPARE_HI, 16'h5A5A);
      apply_settings(make_settings('1, '1, '1, '0, '0, '0, 16'sh7FFF, -16'sh8000));
      send_step(16'sh7FFF, -16'sh8000, -16'sh8000, 0);
      send_step(-1234, 4321, 777, 0);
      wait_all_results();
   endtask

   task automatic test_drive_bounds();
      apply_settings(make_settings(16'd384, 16'd0, 16'd0, '1, '0, '0, 16'sd100, -16'sd100));
      send_step(-3, 0, 0, 0);
      send_step(66, 0, 0, 0);
      send_step(67, 0, 0, 0);
      send_step(-66, 0, 0, 0);
      send_step(-67, 0, 0, 0);
      wait_all_results();
      // inverted bounds
      apply_settings(make_settings(16'd256, 16'd0, 16'd0, '1, '0, '0, -16'sd100, 16'sd100));
      send_step(0, 0, 0, 0);
      send_step(-200, 0, 0, 0);
      wait_all_results();
      apply_settings(make_settings(16'd256, 16'd0, 16'd0, '1, '0, '0, 16'sd50, 16'sd50));
      send_step(49, 0, 0, 0);
      send_step(51, 0, 0, 0);
      wait_all_results();
   endtask

   task automatic test_backpressure();
      apply_settings(random_settings());
      rsp_hold_cycles = 80;
      repeat (20) send_step(random_signal(), random_signal(), random_signal(), 0);
      wait_all_results();
   endtask

   task automatic test_random_phases();
      logic signed [SW-1:0] tgt;
      logic signed [SW-1:0] meas;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(random_settings());
         send_gap_pct  = (phase == 1) ? 0 : 20;
         rsp_stall_pct = (phase == 1) ? 0 : 25;
         for (int n = 0; n < PHASE_STEPS; n++) begin
            tgt = random_signal();
            if ($urandom_range(2) == 0) meas = tgt - (SW'($urandom_range(60)) - 16'sd30);
            else meas = random_signal();
            send_step(tgt, meas, random_signal(), send_gap());
         end
         wait_all_results();
      end
   endtask

   initial begin
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_target          = '0;
      req_measured        = '0;
      req_measured_change = '0;
      csr_valid           = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_defaults();
      test_gain_extremes();
      test_zero_limits();
      test_drive_bounds();
      test_backpressure();
      test_random_phases();
      wait_all_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+src
src/cpid_pkg.sv
src/cpid_product_stage.sv
src/cpid_clamp_stage.sv
src/cpid_output_stage.sv
src/clamped_pid_controller_unit.sv
test/clamped_pid_controller_unit_tb.sv
